// ===== src/mpwc_pkg.sv =====
package mpwc_pkg;

   localparam int DEFAULT_CHANNELS     = 6;
   localparam int DEFAULT_COUNTER_BITS = 32;

   localparam int CHANNEL_W = 3;
   localparam int WIDTH_W   = 16;
   localparam int TPU_W     = 8;
   localparam int PERIOD_W  = 32;
   localparam int CSR_DATA_W = 32;

   localparam logic [TPU_W-1:0]    RESET_TICKS_PER_US   = 8'd50;
   localparam logic [PERIOD_W-1:0] RESET_TIMEOUT_PERIOD = 32'd1000000;

   localparam logic [WIDTH_W-1:0] WIDTH_SATURATED = 16'hFFFF;

   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_EDGE      = 1'b1;
   localparam logic LEVEL_RISING = 1'b1;

   localparam logic REG_TICKS_PER_US   = 1'b0;
   localparam logic REG_TIMEOUT_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic div_start;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

endpackage

// ===== src/mpwc_ctrl.sv =====
module mpwc_ctrl
   import mpwc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold the finished item until the output slot frees up
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/mpwc_dp.sv =====
module mpwc_dp
   import mpwc_pkg::*;
#(
   parameter int CHANNELS     = DEFAULT_CHANNELS,
   parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_operation,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic                  req_pin_level,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [CHANNEL_W-1:0]  rsp_result_channel,
   output logic [WIDTH_W-1:0]    rsp_width_us,
   output logic                  rsp_new_width,
   output logic                  rsp_timed_out
);

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CH_EXT_W = 5;
   localparam int DIV_CNT_W = $clog2(COUNTER_BITS);

   // configuration
   logic [TPU_W-1:0]    tpu_ff;
   logic [PERIOD_W-1:0] period_ff;

   // latched transaction
   logic                 op_ff;
   logic [CHANNEL_W-1:0] ch_ff;
   logic                 level_ff;

   // block state
   logic [COUNTER_BITS-1:0] timer_ff;
   logic [COUNTER_BITS-1:0] capture_ff [CHANNELS];
   logic [WIDTH_W-1:0]      width_ff   [CHANNELS];
   logic                    flag_ff;

   // divider
   logic [TPU_W-1:0]        rem_ff, rem_in;
   logic [COUNTER_BITS-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]    cnt_ff;

   // output register
   logic [CHANNEL_W-1:0] out_ch_ff, out_ch_in;
   logic [WIDTH_W-1:0]   out_width_ff, out_width_in;
   logic                 out_new_ff, out_new_in;

   logic [CH_EXT_W-1:0]     ch_ext;
   logic [CH_IDX_W-1:0]     idx;
   logic                    in_range;
   logic [COUNTER_BITS-1:0] diff;
   logic                    meas_ok;
   logic                    tpu_zero;
   logic [TPU_W:0]          trial_dividend;
   logic [TPU_W:0]          trial;
   logic [31:0]             quo_ext;
   logic [WIDTH_W-1:0]      new_width_val;
   logic [COUNTER_BITS-1:0] reload_val;
   logic                    expire;
   logic                    flag_in;

   assign ch_ext     = CH_EXT_W'(ch_ff);
   assign idx        = ch_ext[CH_IDX_W-1:0];
   assign in_range   = ch_ext < CH_EXT_W'(CHANNELS);
   assign diff       = capture_ff[idx] - timer_ff;
   assign meas_ok    = (op_ff == OP_EDGE) && in_range && (level_ff != LEVEL_RISING)
                       && (diff != '0) && !diff[COUNTER_BITS-1];
   assign tpu_zero   = (tpu_ff == '0);
   assign reload_val = period_ff[COUNTER_BITS-1:0];
   assign expire     = (timer_ff <= COUNTER_BITS'(1));

   assign status.need_div = meas_ok && !tpu_zero;
   assign status.div_last = (cnt_ff == DIV_CNT_W'(COUNTER_BITS - 1));

   // restoring division, one quotient bit per cycle
   assign trial_dividend = {rem_ff, quo_ff[COUNTER_BITS-1]};
   assign trial          = trial_dividend - {1'b0, tpu_ff};

   always_comb begin
      if (trial_dividend >= {1'b0, tpu_ff}) begin
         rem_in = trial[TPU_W-1:0];
         quo_in = {quo_ff[COUNTER_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial_dividend[TPU_W-1:0];
         quo_in = {quo_ff[COUNTER_BITS-2:0], 1'b0};
      end
   end

   assign quo_ext = 32'(quo_ff);

   always_comb begin
      if (tpu_zero || (quo_ext[31:WIDTH_W] != '0)) begin
         new_width_val = WIDTH_SATURATED;
      end else begin
         new_width_val = quo_ext[WIDTH_W-1:0];
      end
   end

   always_comb begin
      out_ch_in    = '0;
      out_width_in = '0;
      out_new_in   = 1'b0;
      flag_in      = flag_ff;
      if (op_ff == OP_TICK) begin
         if (expire) begin
            flag_in = 1'b1;
         end
      end else begin
         out_ch_in = ch_ff;
         if (meas_ok) begin
            out_width_in = new_width_val;
            out_new_in   = 1'b1;
            flag_in      = 1'b0;
         end else if (in_range) begin
            out_width_in = width_ff[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff    <= RESET_TICKS_PER_US;
         period_ff <= RESET_TIMEOUT_PERIOD;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TICKS_PER_US:   tpu_ff    <= csr_write_data[TPU_W-1:0];
            REG_TIMEOUT_PERIOD: period_ff <= csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff    <= req_operation;
         ch_ff    <= req_channel;
         level_ff <= req_pin_level;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= diff;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= COUNTER_BITS'(RESET_TIMEOUT_PERIOD);
         flag_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            capture_ff[i] <= '0;
            width_ff[i]   <= '0;
         end
      end else if (cmd.commit) begin
         flag_ff <= flag_in;
         if (op_ff == OP_TICK) begin
            if (expire) begin
               timer_ff <= reload_val;
               for (int i = 0; i < CHANNELS; i++) begin
                  width_ff[i] <= '0;
               end
            end else begin
               timer_ff <= timer_ff - COUNTER_BITS'(1);
            end
         end else if (in_range) begin
            if (level_ff == LEVEL_RISING) begin
               capture_ff[idx] <= timer_ff;
            end else if (meas_ok) begin
               width_ff[idx] <= new_width_val;
               timer_ff      <= reload_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_ch_ff    <= out_ch_in;
         out_width_ff <= out_width_in;
         out_new_ff   <= out_new_in;
      end
   end

   assign rsp_result_channel = out_ch_ff;
   assign rsp_width_us       = out_width_ff;
   assign rsp_new_width      = out_new_ff;
   assign rsp_timed_out      = flag_ff;

endmodule

// ===== src/multichannel_pulse_width_capture.sv =====
// Pulse-width capture for up to CHANNELS receiver inputs sharing one down-counting
// timeout timer. Each request transaction is either a timer tick or a pin edge on a
// channel; each one yields exactly one response transaction carrying the channel, its
// stored width in microseconds (zero channel and width for a tick), a new-measurement
// flag and the timeout flag. A tick, a rising edge, an ignored edge or a falling edge
// with ticks_per_us at zero goes from acceptance through evaluation to commit; a
// falling edge that completes a valid measurement with a nonzero ticks_per_us also
// runs the restoring divider, which yields one quotient bit per cycle.
// The block works on one transaction at a time, but it accepts the next request while
// a finished response still waits in the output register; a response that is not taken
// holds the block in its final step. Write ticks_per_us (index 0) and timeout_period
// (index 1) only while idle; a new period takes effect at the next timer reload.
module multichannel_pulse_width_capture
   import mpwc_pkg::*;
#(
   parameter int CHANNELS     = DEFAULT_CHANNELS,
   parameter int COUNTER_BITS = DEFAULT_COUNTER_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic                  req_pin_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHANNEL_W-1:0]  rsp_result_channel,
   output logic [WIDTH_W-1:0]    rsp_width_us,
   output logic                  rsp_new_width,
   output logic                  rsp_timed_out,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: accept, evaluate, divide when needed, then commit into the output register
   mpwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // timer, capture and width registers, divider and response payload
   mpwc_dp #(
      .CHANNELS     (CHANNELS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_pin_level      (req_pin_level),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_result_channel (rsp_result_channel),
      .rsp_width_us       (rsp_width_us),
      .rsp_new_width      (rsp_new_width),
      .rsp_timed_out      (rsp_timed_out)
   );

   // a fresh measurement always clears the timeout flag
   a_new_clears_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_width |-> !rsp_timed_out)
      else $error("new width reported with timeout flag set");

   // only an in-range channel can report a fresh measurement
   a_new_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_width |-> (32'(rsp_result_channel) < CHANNELS))
      else $error("new width reported on an out-of-range channel");

   // one transaction at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in flight");

   // the divider runs only for valid falling edges, and every request still passes through
   // the evaluate and commit states, so no response appears right after acceptance
   a_no_early_response: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(rsp_valid && !$past(rsp_valid)))
      else $error("response produced one cycle after acceptance");

endmodule
